### rtl/core/hbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_pkg
// Shared types and constants of the heartbeat monitor.
// ----------------------------------------------------------------------------
package hbm_pkg;

	// input word modes
	localparam logic [1:0] MODE_FEED = 2'd0;
	localparam logic [1:0] MODE_TICK = 2'd1;
	localparam logic [1:0] MODE_LOAD = 2'd2;

	// register indexes (byte address bit 2)
	localparam logic REG_CHANNELS_IN_USE = 1'b0;
	localparam logic REG_MISS_LIMIT      = 1'b1;

	localparam logic [4:0] CHANNELS_IN_USE_RST = 5'd16;
	localparam logic [1:0] MISS_LIMIT_RST      = 2'd3;

	// reports emitted per tick at most
	localparam int MaxResults = 16;
	localparam int KW         = $clog2(MaxResults + 1);

	localparam int FRAC_BITS = 16;
	localparam int DEN_BITS  = 17;

	typedef struct packed {
		logic [4:0] channels_in_use;
		logic [1:0] miss_limit;
	} cfg_t;

endpackage

### rtl/core/hbm_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_apb_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module hbm_apb_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output hbm_pkg::cfg_t      cfg
);

	hbm_pkg::cfg_t cfg_q;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channels_in_use <= hbm_pkg::CHANNELS_IN_USE_RST;
			cfg_q.miss_limit      <= hbm_pkg::MISS_LIMIT_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				hbm_pkg::REG_CHANNELS_IN_USE: cfg_q.channels_in_use <= pwdata[4:0];
				hbm_pkg::REG_MISS_LIMIT:      cfg_q.miss_limit      <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			hbm_pkg::REG_CHANNELS_IN_USE: prdata = {27'd0, cfg_q.channels_in_use};
			hbm_pkg::REG_MISS_LIMIT:      prdata = {30'd0, cfg_q.miss_limit};
			default:                      prdata = 32'd0;
		endcase
	end

endmodule

### rtl/core/hbm_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbm_divider
// Restoring divider, one quotient bit a cycle: floor(num * 2^16 / den).
// ----------------------------------------------------------------------------
module hbm_divider (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [hbm_pkg::FRAC_BITS-1:0]     num,
	input  logic [hbm_pkg::DEN_BITS-1:0]      den,
	output logic                              done,
	output logic [hbm_pkg::FRAC_BITS-1:0]     quot
);

	localparam int SW = $clog2(hbm_pkg::FRAC_BITS);

	logic                            busy_q;
	logic                            done_q;
	logic [SW-1:0]                   step_q;
	logic [hbm_pkg::DEN_BITS-1:0]    den_q;
	logic [hbm_pkg::DEN_BITS-1:0]    rem_q;
	logic [hbm_pkg::FRAC_BITS-1:0]   quot_q;
	logic [hbm_pkg::DEN_BITS:0]      trial;
	logic                            fits;

	assign trial = {rem_q, 1'b0};
	assign fits  = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				den_q  <= den;
				step_q <= '0;
				if (den == '0) begin
					quot_q <= '0;
					done_q <= 1'b1;
				end else if ({1'b0, num} >= den) begin
					// quotient would not fit, saturate
					quot_q <= '1;
					done_q <= 1'b1;
				end else begin
					rem_q  <= {1'b0, num};
					quot_q <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (fits) begin
					rem_q  <= hbm_pkg::DEN_BITS'(trial - {1'b0, den_q});
					quot_q <= {quot_q[hbm_pkg::FRAC_BITS-2:0], 1'b1};
				end else begin
					rem_q  <= trial[hbm_pkg::DEN_BITS-1:0];
					quot_q <= {quot_q[hbm_pkg::FRAC_BITS-2:0], 1'b0};
				end
				step_q <= step_q + 1'b1;
				if (step_q == SW'(hbm_pkg::FRAC_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/core/multi_channel_heartbeat_monitor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_monitor_top
// Per-channel activity counters checked against thresholds on each tick.
// ----------------------------------------------------------------------------
// feed and load words leave ready high; the next word is taken the cycle after
// tick word: ready stays low while each checked channel is walked, for the
// finish, for each report (16-step shared divider, no steps when the divisor
// is zero or the fraction saturates) and for any wait on the output side
// a report is held back by one word so the last one of a tick carries tlast
// reset clears all counters and thresholds at once; registers take defaults
module multi_channel_heartbeat_monitor_top #(
	parameter int CHANNELS   = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // channel[4:0], threshold_value[20:5]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // report_channel[3:0], activity_count[19:4],
	                               // activity_fraction[35:20]
	output logic        m_tlast,   // last_report
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NW    = $clog2(CHANNELS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_WALK   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_PUSH   = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	hbm_pkg::cfg_t cfg;

	logic [COUNT_BITS-1:0] act_q  [CHANNELS];
	logic [1:0]            miss_q [CHANNELS];
	logic [15:0]           thr_q  [CHANNELS];

	logic [2:0]            state_q;
	logic [IDX_W-1:0]      idx_q;
	logic [NW-1:0]         n_q;
	logic [hbm_pkg::KW-1:0] k_q;

	logic [3:0]            rep_ch_q;
	logic [15:0]           rep_cnt_q;
	logic                  pend_valid_q;
	logic [3:0]            pend_ch_q;
	logic [15:0]           pend_cnt_q;
	logic [15:0]           pend_frac_q;

	logic                  m_tvalid_q;
	logic [39:0]           m_tdata_q;
	logic                  m_tlast_q;

	logic [1:0]            in_mode;
	logic [4:0]            in_ch;
	logic [15:0]           in_thr;
	logic                  in_acc;
	logic                  in_range;
	logic [IDX_W-1:0]      in_idx;
	logic [NW-1:0]         n_next;

	logic [31:0]           cur_cnt;
	logic [15:0]           cur_cnt16;
	logic [15:0]           cur_thr;
	logic                  short_fall;
	logic [1:0]            miss_inc;
	logic                  hit_limit;
	logic                  idx_last;
	logic                  out_free;
	logic                  out_load;

	logic                  div_start;
	logic                  div_done;
	logic [hbm_pkg::DEN_BITS-1:0]  div_den;
	logic [hbm_pkg::FRAC_BITS-1:0] div_quot;

	hbm_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_mode  = s_tuser;
	assign in_ch    = s_tdata[4:0];
	assign in_thr   = s_tdata[20:5];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign in_range = {1'b0, in_ch} < 6'(CHANNELS);
	assign in_idx   = in_ch[IDX_W-1:0];
	assign n_next   = ({1'b0, cfg.channels_in_use} > 6'(CHANNELS)) ?
	                  NW'(CHANNELS) : NW'(cfg.channels_in_use);

	assign cur_cnt    = 32'(act_q[idx_q]);
	assign cur_cnt16  = (|cur_cnt[31:16]) ? 16'hFFFF : cur_cnt[15:0];
	assign cur_thr    = thr_q[idx_q];
	assign short_fall = cur_cnt < 32'(cur_thr);
	assign miss_inc   = miss_q[idx_q] + 2'd1;
	assign hit_limit  = miss_inc >= cfg.miss_limit;
	assign idx_last   = (NW'(idx_q) + NW'(1)) == n_q;
	assign out_free   = ~m_tvalid_q | m_tready;
	assign out_load   = pend_valid_q && out_free &&
	                    (state_q == ST_PUSH || state_q == ST_FINISH);

	// floor(thr * 5 / 4) = thr + floor(thr / 4)
	assign div_den   = hbm_pkg::DEN_BITS'(cur_thr) + hbm_pkg::DEN_BITS'(cur_thr >> 2);
	assign div_start = (state_q == ST_WALK) && short_fall && hit_limit &&
	                   (k_q < hbm_pkg::KW'(hbm_pkg::MaxResults));

	hbm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (cur_cnt16),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// channel storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				act_q[i]  <= '0;
				miss_q[i] <= '0;
				thr_q[i]  <= '0;
			end
		end else if (in_acc && in_range) begin
			if (in_mode == hbm_pkg::MODE_FEED) begin
				if (act_q[in_idx] != '1)
					act_q[in_idx] <= act_q[in_idx] + 1'b1;
			end else if (in_mode == hbm_pkg::MODE_LOAD) begin
				thr_q[in_idx] <= in_thr;
			end
		end else if (state_q == ST_WALK) begin
			act_q[idx_q] <= '0;
			if (short_fall && !hit_limit)
				miss_q[idx_q] <= miss_inc;
			else
				miss_q[idx_q] <= '0;
		end
	end

	// tick sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			n_q          <= '0;
			k_q          <= '0;
			rep_ch_q     <= '0;
			rep_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
			pend_ch_q    <= '0;
			pend_cnt_q   <= '0;
			pend_frac_q  <= '0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tlast_q    <= 1'b0;
		end else begin
			if (m_tready && !out_load)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && in_mode == hbm_pkg::MODE_TICK) begin
						idx_q        <= '0;
						k_q          <= '0;
						pend_valid_q <= 1'b0;
						n_q          <= n_next;
						if (n_next != '0)
							state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (div_start) begin
						rep_ch_q  <= 4'(idx_q);
						rep_cnt_q <= cur_cnt16;
						state_q   <= ST_DIV;
					end else if (idx_last) begin
						state_q <= ST_FINISH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (div_done)
						state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					// hold one report back so the last one can be marked
					if (!pend_valid_q || out_free) begin
						if (pend_valid_q) begin
							m_tvalid_q <= 1'b1;
							m_tdata_q  <= {4'd0, pend_frac_q, pend_cnt_q, pend_ch_q};
							m_tlast_q  <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_ch_q    <= rep_ch_q;
						pend_cnt_q   <= rep_cnt_q;
						pend_frac_q  <= div_quot;
						k_q          <= k_q + 1'b1;
						if (idx_last) begin
							state_q <= ST_FINISH;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_WALK;
						end
					end
				end
				ST_FINISH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						m_tvalid_q   <= 1'b1;
						m_tdata_q    <= {4'd0, pend_frac_q, pend_cnt_q, pend_ch_q};
						m_tlast_q    <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
